/* design/lsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_pkg
// Shared types, constants and codes for the load/store unit.
// ----------------------------------------------------------------------------
package lsu_pkg;

  // Data memory size in bytes and its address width
  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);

  // Register file
  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);

  typedef enum logic [1:0] {
    OP_EXEC     = 2'd0,
    OP_POKE_MEM = 2'd1,
    OP_POKE_REG = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_BASE,
    ST_RD_OFFS,
    ST_RD_DATA,
    ST_ADDR,
    ST_CHECK,
    ST_WB,
    ST_BYTES,
    ST_LOAD_WB,
    ST_POKE_REG,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic rd_base;
    logic rd_offs;
    logic rd_data;
    logic calc;
    logic check;
    logic wb;
    logic byte_step;
    logic load_wb;
    logic poke_reg;
    logic res_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic oor;
    logic bytes_done;
    logic is_load;
  } sts_t;

endpackage

/* design/load_store_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_store_unit
// Single data transfer unit: register file plus little-endian byte memory,
// with scaled, register, pre/post-indexed and PC-relative literal modes.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------
//  input   | in_valid / in_stall  | op, instr, pc, poke_addr, poke_data,
//          |                      | reg_index
//  output  | out_valid / out_stall| access_addr, xfer_data, was_load,
//          |                      | target_reg, base_updated, status
//
// Transactions run one at a time: a new one is accepted only after the
// previous one has reached its hand-off. An executed access makes three
// reads through the one-port register file, then moves its bytes, one
// byte per cycle, through the single-port byte memory; out-of-range
// accesses skip the byte transfers.
// Reset is synchronous; afterwards a clearing pass zeroes the byte memory,
// one byte a cycle, all MEM_BYTES (65536) bytes, with in_stall held high.
// The result sits in an output register; the next transaction is taken
// while it waits, and the block holds in its hand-off state on out_stall.
// ----------------------------------------------------------------------------
module load_store_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] instr,
  input  logic [31:0] pc,
  input  logic [15:0] poke_addr,
  input  logic [63:0] poke_data,
  input  logic [4:0]  reg_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] access_addr,
  output logic [63:0] xfer_data,
  output logic        was_load,
  output logic [4:0]  target_reg,
  output logic        base_updated,
  output logic        status
);

  // Command and status between sequencer and datapath
  lsu_pkg::cmd_t cmd;
  lsu_pkg::sts_t sts;

  // Sequencer: drives both handshakes and steps the datapath
  lsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: captures the transaction, owns both stores and the result
  lsu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .instr        (instr),
    .pc           (pc),
    .poke_addr    (poke_addr),
    .poke_data    (poke_data),
    .reg_index    (reg_index),
    .access_addr  (access_addr),
    .xfer_data    (xfer_data),
    .was_load     (was_load),
    .target_reg   (target_reg),
    .base_updated (base_updated),
    .status       (status)
  );

endmodule

/* design/lsu_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_regfile
// 64-bit register file, one write and one registered read port, with
// per-entry valid bits so that unwritten registers read as zero after reset.
// ----------------------------------------------------------------------------
module lsu_regfile (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [lsu_pkg::REG_AW-1:0]   waddr,
  input  logic [63:0]                  wdata,
  input  logic [lsu_pkg::REG_AW-1:0]   raddr,
  output logic [63:0]                  rdata
);

  logic [63:0]                    rf_mem [lsu_pkg::REG_COUNT];
  logic [lsu_pkg::REG_COUNT-1:0]  vld;
  logic [63:0]                    rdata_q;
  logic                           rvld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      rf_mem[waddr] <= wdata;
    end
    rdata_q <= rf_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rvld_q <= vld[raddr];
    end
  end

  assign rdata = rvld_q ? rdata_q : 64'd0;

endmodule

/* design/lsu_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_datapath
// Operand registers, address adders, range check, byte memory, register
// file and result registers of the load/store unit.
// ----------------------------------------------------------------------------
module lsu_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  lsu_pkg::cmd_t        cmd,
  output lsu_pkg::sts_t        sts,
  input  logic [1:0]           op,
  input  logic [31:0]          instr,
  input  logic [31:0]          pc,
  input  logic [15:0]          poke_addr,
  input  logic [63:0]          poke_data,
  input  logic [4:0]           reg_index,
  output logic [63:0]          access_addr,
  output logic [63:0]          xfer_data,
  output logic                 was_load,
  output logic [4:0]           target_reg,
  output logic                 base_updated,
  output logic                 status
);

  // Captured transaction
  lsu_pkg::op_t  op_q;
  logic [31:0]   instr_q;
  logic [31:0]   pc_q;
  logic [4:0]    idx_q;

  // Working registers
  logic [63:0]   base_q;
  logic [63:0]   offs_q;
  logic [63:0]   addr_q;
  logic [63:0]   newbase_q;
  logic [63:0]   data_q;
  logic          wb_q;
  logic          oor_q;
  logic [3:0]    cnt;

  // Clearing pass
  logic [lsu_pkg::MEM_AW-1:0] clr_addr;

  // Byte memory
  logic [7:0]                 dmem [lsu_pkg::MEM_BYTES];
  logic [7:0]                 mem_rbyte;
  logic                       mem_we;
  logic                       mem_re;
  logic [lsu_pkg::MEM_AW-1:0] byte_addr;
  logic [lsu_pkg::MEM_AW-1:0] mem_waddr;
  logic [7:0]                 mem_wdata;

  // Register file port
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [63:0] rf_wdata;
  logic [4:0]  rf_raddr;
  logic [63:0] rf_rdata;

  // Decode
  logic [4:0]  rt, rn, rm;
  logic        is_lit, size8, load, is_exec, eff_load;
  logic [63:0] simm9, simm19x4, imm12x;
  logic [63:0] sum_a, sum_b, addr_sum, nb_sum;
  logic [3:0]  n_bytes;
  logic [63:0] lim;
  logic [2:0]  cap_idx;
  logic [63:0] st_val;

  assign rt       = instr_q[4:0];
  assign rn       = instr_q[9:5];
  assign rm       = instr_q[20:16];
  assign is_lit   = ~instr_q[31];
  assign size8    = instr_q[30];
  assign load     = is_lit | instr_q[22];
  assign is_exec  = (op_q == lsu_pkg::OP_EXEC);
  assign eff_load = is_exec & load;

  assign simm9    = {{55{instr_q[20]}}, instr_q[20:12]};
  assign simm19x4 = {{43{instr_q[23]}}, instr_q[23:5], 2'b00};
  assign imm12x   = size8 ? {49'd0, instr_q[21:10], 3'b000}
                          : {50'd0, instr_q[21:10], 2'b00};

  // Address adder: literal, scaled, register, pre-index, post-index
  always_comb begin
    sum_a = is_lit ? {32'd0, pc_q} : base_q;
    priority if (is_lit) begin
      sum_b = simm19x4;
    end else if (instr_q[24]) begin
      sum_b = imm12x;
    end else if (instr_q[21]) begin
      sum_b = offs_q;
    end else if (instr_q[11]) begin
      sum_b = simm9;
    end else begin
      sum_b = 64'd0;
    end
  end

  assign addr_sum = sum_a + sum_b;
  assign nb_sum   = base_q + simm9;

  assign n_bytes  = (op_q == lsu_pkg::OP_POKE_MEM || size8) ? 4'd8 : 4'd4;
  assign lim      = 64'(lsu_pkg::MEM_BYTES) - {60'd0, n_bytes};

  assign st_val   = (wb_q && rt == rn) ? newbase_q : data_q;

  // Operand and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= lsu_pkg::op_t'(op);
      instr_q <= instr;
      pc_q    <= pc;
      idx_q   <= reg_index;
      addr_q  <= {48'd0, poke_addr};
      data_q  <= poke_data;
    end else if (cmd.rd_offs) begin
      base_q <= rf_rdata;
    end else if (cmd.rd_data) begin
      offs_q <= rf_rdata;
    end else if (cmd.calc) begin
      data_q    <= rf_rdata;
      addr_q    <= addr_sum;
      newbase_q <= nb_sum;
      wb_q      <= ~is_lit & ~instr_q[24] & ~instr_q[21];
    end else if (cmd.check) begin
      oor_q <= (addr_q > lim);
    end else if (cmd.wb) begin
      if (is_exec) begin
        if (oor_q || load) begin
          data_q <= 64'd0;
        end else if (size8) begin
          data_q <= st_val;
        end else begin
          data_q <= {32'd0, st_val[31:0]};
        end
      end
    end else if (cmd.byte_step) begin
      if (eff_load && cnt != 4'd0) begin
        data_q[{cap_idx, 3'b000} +: 8] <= mem_rbyte;
      end
    end
  end

  // Byte counter: hold at the byte count on the last transfer cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
    end else if (cmd.wb) begin
      cnt <= 4'd0;
    end else if (cmd.byte_step && cnt != n_bytes) begin
      cnt <= cnt + 4'd1;
    end
  end

  assign cap_idx = cnt[2:0] - 3'd1;

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + lsu_pkg::MEM_AW'(1);
    end
  end

  // Byte memory port
  assign byte_addr = addr_q[lsu_pkg::MEM_AW-1:0] + lsu_pkg::MEM_AW'(cnt[2:0]);
  assign mem_we    = cmd.clr_step | (cmd.byte_step & ~eff_load & (cnt < n_bytes));
  assign mem_re    = cmd.byte_step & eff_load & (cnt < n_bytes);
  assign mem_waddr = cmd.clr_step ? clr_addr : byte_addr;
  assign mem_wdata = cmd.clr_step ? 8'd0 : data_q[{cnt[2:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rbyte <= dmem[byte_addr];
    end
  end

  // Register file
  assign rf_we    = (cmd.wb & is_exec & ~oor_q & wb_q) | cmd.load_wb | cmd.poke_reg;
  assign rf_waddr = cmd.load_wb ? rt : (cmd.poke_reg ? idx_q : rn);
  assign rf_wdata = (cmd.load_wb || cmd.poke_reg) ? data_q : newbase_q;
  assign rf_raddr = cmd.rd_offs ? rm : (cmd.rd_data ? rt : rn);

  lsu_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (op_q)
        lsu_pkg::OP_EXEC: begin
          access_addr  <= addr_q;
          xfer_data    <= data_q;
          was_load     <= load;
          target_reg   <= rt;
          base_updated <= wb_q & ~oor_q;
          status       <= oor_q;
        end
        lsu_pkg::OP_POKE_MEM: begin
          access_addr  <= addr_q;
          xfer_data    <= data_q;
          was_load     <= 1'b0;
          target_reg   <= 5'd0;
          base_updated <= 1'b0;
          status       <= oor_q;
        end
        lsu_pkg::OP_POKE_REG: begin
          access_addr  <= 64'd0;
          xfer_data    <= data_q;
          was_load     <= 1'b0;
          target_reg   <= idx_q;
          base_updated <= 1'b0;
          status       <= 1'b0;
        end
        default: begin
          access_addr  <= 64'd0;
          xfer_data    <= 64'd0;
          was_load     <= 1'b0;
          target_reg   <= 5'd0;
          base_updated <= 1'b0;
          status       <= 1'b0;
        end
      endcase
    end
  end

  assign sts.clr_last   = (clr_addr == lsu_pkg::MEM_AW'(lsu_pkg::MEM_BYTES - 1));
  assign sts.oor        = oor_q;
  assign sts.bytes_done = (cnt == n_bytes);
  assign sts.is_load    = eff_load;

  // No register write-back or memory write for an out-of-range access
  a_no_wb_oor: assert property (@(posedge clk) disable iff (rst)
    cmd.wb && oor_q |-> !rf_we)
    else $error("base write-back on out-of-range access");

  a_no_write_oor: assert property (@(posedge clk) disable iff (rst)
    cmd.byte_step && !cmd.clr_step && mem_we |-> !oor_q)
    else $error("memory write on out-of-range access");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 4'd8)
    else $error("byte counter overrun");

endmodule

/* design/lsu_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsu_ctrl
// Sequencer of the load/store unit: clearing pass, operand reads, address,
// range check, write-back, byte transfers, register writes, result hand-off.
// ----------------------------------------------------------------------------
module lsu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  output logic               out_valid,
  input  logic               out_stall,
  output lsu_pkg::cmd_t      cmd,
  input  lsu_pkg::sts_t      sts
);

  lsu_pkg::state_t state, state_next;
  logic            res_free;

  assign res_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsu_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lsu_pkg::ST_CLEAR:    if (sts.clr_last) state_next = lsu_pkg::ST_IDLE;
      lsu_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (lsu_pkg::op_t'(op))
            lsu_pkg::OP_EXEC:     state_next = lsu_pkg::ST_RD_BASE;
            lsu_pkg::OP_POKE_MEM: state_next = lsu_pkg::ST_CHECK;
            lsu_pkg::OP_POKE_REG: state_next = lsu_pkg::ST_POKE_REG;
            default:              state_next = lsu_pkg::ST_DONE;
          endcase
        end
      end
      lsu_pkg::ST_RD_BASE:  state_next = lsu_pkg::ST_RD_OFFS;
      lsu_pkg::ST_RD_OFFS:  state_next = lsu_pkg::ST_RD_DATA;
      lsu_pkg::ST_RD_DATA:  state_next = lsu_pkg::ST_ADDR;
      lsu_pkg::ST_ADDR:     state_next = lsu_pkg::ST_CHECK;
      lsu_pkg::ST_CHECK:    state_next = lsu_pkg::ST_WB;
      lsu_pkg::ST_WB:       state_next = sts.oor ? lsu_pkg::ST_DONE : lsu_pkg::ST_BYTES;
      lsu_pkg::ST_BYTES: begin
        if (sts.bytes_done) begin
          state_next = sts.is_load ? lsu_pkg::ST_LOAD_WB : lsu_pkg::ST_DONE;
        end
      end
      lsu_pkg::ST_LOAD_WB:  state_next = lsu_pkg::ST_DONE;
      lsu_pkg::ST_POKE_REG: state_next = lsu_pkg::ST_DONE;
      lsu_pkg::ST_DONE:     if (res_free) state_next = lsu_pkg::ST_IDLE;
      default:              state_next = lsu_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      lsu_pkg::ST_CLEAR:    cmd.clr_step = 1'b1;
      lsu_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      lsu_pkg::ST_RD_BASE:  cmd.rd_base   = 1'b1;
      lsu_pkg::ST_RD_OFFS:  cmd.rd_offs   = 1'b1;
      lsu_pkg::ST_RD_DATA:  cmd.rd_data   = 1'b1;
      lsu_pkg::ST_ADDR:     cmd.calc      = 1'b1;
      lsu_pkg::ST_CHECK:    cmd.check     = 1'b1;
      lsu_pkg::ST_WB:       cmd.wb        = 1'b1;
      lsu_pkg::ST_BYTES:    cmd.byte_step = 1'b1;
      lsu_pkg::ST_LOAD_WB:  cmd.load_wb   = 1'b1;
      lsu_pkg::ST_POKE_REG: cmd.poke_reg  = 1'b1;
      lsu_pkg::ST_DONE:     cmd.res_load  = res_free;
      default:              cmd           = '0;
    endcase
  end

  // Output register valid: set on result load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == lsu_pkg::ST_DONE)
    else $error("result valid raised outside hand-off");

  a_clear_no_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !cmd.capture && in_stall)
    else $error("transaction taken during clearing pass");

endmodule
